@@ rtl/gn3t_pkg.sv @@
// -----------------------------------------------------------------------------
// gn3t_pkg: shared types and constants
// Operation codes and field widths of the gradient noise block.
// -----------------------------------------------------------------------------
package gn3t_pkg;

    localparam int OpW     = 3;
    localparam int IdxW    = 8;
    localparam int PermW   = 8;
    localparam int GradW   = 16;
    localparam int PointW  = 32;
    localparam int NoiseW  = 20;
    localparam int CfgW    = 4;

    localparam logic [CfgW-1:0] OctaveCountReset = 4'd7;

    typedef enum logic [OpW-1:0] {
        OP_WR_GRAD   = 3'd0,
        OP_WR_PERM_X = 3'd1,
        OP_WR_PERM_Y = 3'd2,
        OP_WR_PERM_Z = 3'd3,
        OP_NOISE     = 3'd4,
        OP_TURB      = 3'd5
    } t_op;

endpackage

@@ rtl/gn3t_req_if.sv @@
// -----------------------------------------------------------------------------
// gn3t_req_if: request channel
// Valid/ready channel that carries one load or evaluate item.
// -----------------------------------------------------------------------------
interface gn3t_req_if;
    import gn3t_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OpW-1:0]           operation;
    logic [IdxW-1:0]          table_index;
    logic [PermW-1:0]         perm_value;
    logic signed [GradW-1:0]  grad_x;
    logic signed [GradW-1:0]  grad_y;
    logic signed [GradW-1:0]  grad_z;
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic signed [PointW-1:0] point_z;

    modport source (output valid, operation, table_index, perm_value, grad_x, grad_y,
                    grad_z, point_x, point_y, point_z, input ready);
    modport sink (input valid, operation, table_index, perm_value, grad_x, grad_y,
                  grad_z, point_x, point_y, point_z, output ready);
endinterface

@@ rtl/gn3t_rsp_if.sv @@
// -----------------------------------------------------------------------------
// gn3t_rsp_if: result channel
// Valid/ready channel that carries one noise result item.
// -----------------------------------------------------------------------------
interface gn3t_rsp_if;
    import gn3t_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [NoiseW-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

@@ rtl/gradient_noise_3d_turbulence.sv @@
// -----------------------------------------------------------------------------
// gradient_noise_3d_turbulence: 3-D gradient noise with turbulence
// Iterative evaluator built around one shared signed multiplier.
// -----------------------------------------------------------------------------
// Load items (gradient or x/y/z permutation writes) are written when accepted and
// give no result. A noise item evaluates a single octave before the result handoff,
// and a turbulence item evaluates up to octave_count octaves (capped at
// MAX_OCTAVES). The pace is set by the single 36x19-bit multiplier: six
// products per octave build the three smoothstep weights, and each of the
// eight lattice corners then needs six products plus the table reads. The
// block takes no new item while it evaluates or while its result waits on the
// output. Tables hold whatever software loaded; they must be loaded before
// points are evaluated.
module gradient_noise_3d_turbulence #(
    parameter int TABLE_SIZE  = 256,
    parameter int MAX_OCTAVES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gn3t_pkg::CfgW-1:0]  i_cfg_data,
    gn3t_req_if.sink                   i_req,
    gn3t_rsp_if.source                 o_rsp
);
    import gn3t_pkg::*;

    localparam int TW     = $clog2(TABLE_SIZE);
    localparam int OW     = $clog2(MAX_OCTAVES + 1);
    localparam int OctW   = 34;
    localparam int AccW   = OctW + MAX_OCTAVES + 1;
    localparam int FinSh  = MAX_OCTAVES + 7;

    typedef enum logic [2:0] {
        S_IDLE, S_SMOOTH, S_CORNER, S_OCT, S_FIN, S_OUT
    } t_state;

    // Table storage; contents are only meaningful after software loads them.
    logic [3*GradW-1:0] grad_mem [TABLE_SIZE];
    logic [PermW-1:0]   permx_mem [TABLE_SIZE];
    logic [PermW-1:0]   permy_mem [TABLE_SIZE];
    logic [PermW-1:0]   permz_mem [TABLE_SIZE];

    t_state                   r_state;
    logic [CfgW-1:0]          r_cfg;
    logic                     r_turb;
    logic [OW-1:0]            r_cnt;
    logic [OW-1:0]            r_oct;
    logic [2:0]               r_step;
    logic [2:0]               r_corner;
    logic [PointW-1:0]        r_px, r_py, r_pz;
    logic [16:0]              r_sx, r_sy, r_sz;
    logic [16:0]              r_wxyz;
    logic signed [34:0]       r_dot;
    logic signed [55:0]       r_sum;
    logic signed [AccW-1:0]   r_acc;
    logic signed [54:0]       r_prod;
    logic signed [NoiseW-1:0] r_res;
    logic [PermW-1:0]         r_permx_q, r_permy_q, r_permz_q;
    logic [3*GradW-1:0]       r_grad_q;

    logic                     accept;
    logic [TW-1:0]            wr_idx;
    logic [TW-1:0]            ax, ay, az, hash;
    logic signed [35:0]       m_a;
    logic signed [18:0]       m_b;
    logic signed [54:0]       m_p;
    logic [15:0]              fx, fy, fz;
    logic [16:0]              wx, wy, wz;
    logic signed [16:0]       ox, oy, oz;
    logic signed [GradW-1:0]  gx, gy, gz;
    logic signed [54:0]       rnd_s, rnd_w;
    logic signed [55:0]       oct_rnd;
    logic signed [OctW-1:0]   oct_val;
    logic signed [OctW-9:0]   noise_rnd;
    logic signed [AccW-1:0]   acc_abs;
    logic [AccW-FinSh:0]      turb_rnd;
    logic [OW-1:0]            cnt_sel;
    logic signed [NoiseW-1:0] noise_sat, turb_sat;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.noise_value = r_res;
    assign wr_idx      = TW'(i_req.table_index);

    // Lattice cell and fraction of the current octave's point.
    assign fx = r_px[15:0];
    assign fy = r_py[15:0];
    assign fz = r_pz[15:0];
    assign ax = TW'(r_px[16 +: TW] + TW'(r_corner[2]));
    assign ay = TW'(r_py[16 +: TW] + TW'(r_corner[1]));
    assign az = TW'(r_pz[16 +: TW] + TW'(r_corner[0]));
    assign hash = TW'(r_permx_q ^ r_permy_q ^ r_permz_q);

    // Corner weights and offsets; an offset toward the far corner is f - 1.
    assign wx = r_corner[2] ? r_sx : 17'd65536 - r_sx;
    assign wy = r_corner[1] ? r_sy : 17'd65536 - r_sy;
    assign wz = r_corner[0] ? r_sz : 17'd65536 - r_sz;
    assign ox = {r_corner[2], fx};
    assign oy = {r_corner[1], fy};
    assign oz = {r_corner[0], fz};
    assign gx = r_grad_q[3*GradW-1 -: GradW];
    assign gy = r_grad_q[2*GradW-1 -: GradW];
    assign gz = r_grad_q[GradW-1:0];

    assign rnd_s = r_prod + (55'sd1 <<< 31);
    assign rnd_w = r_prod + 55'sd32768;

    // Operand selection for the shared multiplier.
    always_comb begin
        m_a = '0;
        m_b = '0;
        if (r_state == S_SMOOTH) begin
            case (r_step)
                3'd0: begin
                    m_a = 36'(fx);
                    m_b = 19'(fx);
                end
                3'd1: begin
                    m_a = 36'(r_prod[31:0]);
                    m_b = 19'(19'd196608 - {2'b0, fx, 1'b0});
                end
                3'd2: begin
                    m_a = 36'(fy);
                    m_b = 19'(fy);
                end
                3'd3: begin
                    m_a = 36'(r_prod[31:0]);
                    m_b = 19'(19'd196608 - {2'b0, fy, 1'b0});
                end
                3'd4: begin
                    m_a = 36'(fz);
                    m_b = 19'(fz);
                end
                3'd5: begin
                    m_a = 36'(r_prod[31:0]);
                    m_b = 19'(19'd196608 - {2'b0, fz, 1'b0});
                end
                default: begin
                    m_a = '0;
                    m_b = '0;
                end
            endcase
        end else if (r_state == S_CORNER) begin
            case (r_step)
                3'd0: begin
                    m_a = 36'(wx);
                    m_b = 19'(wy);
                end
                3'd1: begin
                    m_a = 36'(rnd_w[32:16]);
                    m_b = 19'(wz);
                end
                3'd2: begin
                    m_a = 36'(ox);
                    m_b = 19'(gx);
                end
                3'd3: begin
                    m_a = 36'(oy);
                    m_b = 19'(gy);
                end
                3'd4: begin
                    m_a = 36'(oz);
                    m_b = 19'(gz);
                end
                3'd6: begin
                    m_a = 36'(r_dot);
                    m_b = 19'(r_wxyz);
                end
                default: begin
                    m_a = '0;
                    m_b = '0;
                end
            endcase
        end
    end

    assign m_p = m_a * m_b;

    // Octave rounding and the two output saturations.
    assign oct_rnd   = r_sum + 56'sd2097152;
    assign oct_val   = oct_rnd[55:22];
    assign noise_rnd = (OctW-8)'((oct_val + OctW'(128)) >>> 8);
    assign noise_sat = (noise_rnd > (OctW-8)'(524287)) ? 20'sd524287 :
                       (noise_rnd < -(OctW-8)'(524288)) ? -20'sd524288 :
                       NoiseW'(noise_rnd);
    assign acc_abs   = r_acc[AccW-1] ? -r_acc : r_acc;
    assign turb_rnd  = (AccW-FinSh+1)'(
                           (AccW+1)'(acc_abs + (AccW'(1) <<< (FinSh - 1))) >> FinSh);
    assign turb_sat  = (turb_rnd > (AccW-FinSh+1)'(524287)) ? 20'sd524287 :
                       NoiseW'(turb_rnd);
    assign cnt_sel   = (32'(r_cfg) > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(r_cfg);

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (accept && i_req.operation == OP_WR_GRAD) begin
            grad_mem[wr_idx] <= {i_req.grad_x, i_req.grad_y, i_req.grad_z};
        end
        r_grad_q <= grad_mem[hash];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.operation == OP_WR_PERM_X) begin
            permx_mem[wr_idx] <= i_req.perm_value;
        end
        r_permx_q <= permx_mem[ax];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.operation == OP_WR_PERM_Y) begin
            permy_mem[wr_idx] <= i_req.perm_value;
        end
        r_permy_q <= permy_mem[ay];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.operation == OP_WR_PERM_Z) begin
            permz_mem[wr_idx] <= i_req.perm_value;
        end
        r_permz_q <= permz_mem[az];
    end

    // Sequencer: smoothstep weights, eight corners, octave wrap-up, then result output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= OctaveCountReset;
            r_step  <= '0;
            r_corner <= '0;
            r_oct   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_prod <= m_p;
            case (r_state)
                S_IDLE: begin
                    r_px   <= i_req.point_x;
                    r_py   <= i_req.point_y;
                    r_pz   <= i_req.point_z;
                    r_step <= '0;
                    r_corner <= '0;
                    r_oct  <= '0;
                    r_sum  <= '0;
                    r_acc  <= '0;
                    r_cnt  <= cnt_sel;
                    if (accept && i_req.operation == OP_NOISE) begin
                        r_turb  <= 1'b0;
                        r_state <= S_SMOOTH;
                    end else if (accept && i_req.operation == OP_TURB) begin
                        r_turb  <= 1'b1;
                        r_state <= (cnt_sel == '0) ? S_FIN : S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    if (r_step == 3'd2) begin
                        r_sx <= rnd_s[48:32];
                    end
                    if (r_step == 3'd4) begin
                        r_sy <= rnd_s[48:32];
                    end
                    if (r_step == 3'd6) begin
                        r_sz    <= rnd_s[48:32];
                        r_step  <= '0;
                        r_state <= S_CORNER;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_CORNER: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd2: r_wxyz <= rnd_w[32:16];
                        3'd3: r_dot <= r_prod[34:0];
                        3'd4: r_dot <= r_dot + r_prod[34:0];
                        3'd5: r_dot <= r_dot + r_prod[34:0];
                        3'd7: begin
                            r_sum    <= r_sum + 56'(r_prod);
                            r_corner <= r_corner + 3'd1;
                            if (r_corner == 3'd7) begin
                                r_state <= S_OCT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_OCT: begin
                    r_sum  <= '0;
                    r_step <= '0;
                    if (!r_turb) begin
                        r_res   <= noise_sat;
                        r_state <= S_OUT;
                    end else begin
                        r_acc <= r_acc + (AccW'(oct_val) <<< (OW'(MAX_OCTAVES - 1) - r_oct));
                        r_px  <= r_px << 1;
                        r_py  <= r_py << 1;
                        r_pz  <= r_pz << 1;
                        r_oct <= r_oct + OW'(1);
                        r_state <= (r_oct + OW'(1) == r_cnt) ? S_FIN : S_SMOOTH;
                    end
                end
                S_FIN: begin
                    r_res   <= turb_sat;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
